/* rtl/core/contiguous_fit_allocator_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CFA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication checked outside reset.
`define CFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/cfa_pkg.sv */
// Package with constants and types for the contiguous fit allocator.
package cfa_pkg;
  localparam int MaxSegments = 16;
  localparam int AddrBits    = 16;
  localparam int IdxBits     = $clog2(MaxSegments);
  localparam int CntBits     = $clog2(MaxSegments + 1);

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_COMPACT = 2'd2,
    CMD_STATUS  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_WORST = 2'd2,
    STRAT_BAD   = 2'd3
  } strat_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_STRATEGY = 3'd1,
    ST_NO_FIT       = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_TABLE_FULL   = 3'd4
  } status_t;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] size;
    logic                free;
    logic [7:0]          owner;
  } seg_t;
endpackage

/* rtl/core/contiguous_fit_allocator.sv */
// Contiguous fit allocator: segment table, command sequencer and result port.
// Commands: request scans the table and may shift entries to split a segment, compact packs
// the used segments, status streams one result per segment (max 16), and release frees the
// owner's segments, then merges free neighbours with shifts.
// Throughput: one command at a time; the next is accepted after its last result.
// Reset (rst, synchronous, high) loads one free segment [0, 1024); a config write loads [0, cfg_data).
`include "contiguous_fit_allocator_macros.svh"

module contiguous_fit_allocator
  import cfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,       // total_memory
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // command[1:0], owner_id[9:2], request_size[25:10]
  input  logic [1:0]  s_axis_tuser,   // strategy
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // status[2:0], seg_start[18:3], seg_size[34:19],
                                      // seg_free[35], seg_owner[43:36], zero fill
  output logic        m_axis_tlast    // last
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SCAN    = 8'b0000_0010,
    S_SHIFT   = 8'b0000_0100,
    S_RELEASE = 8'b0000_1000,
    S_MERGE   = 8'b0001_0000,
    S_COMPACT = 8'b0010_0000,
    S_DUMP    = 8'b0100_0000,
    S_OUT     = 8'b1000_0000
  } state_t;

  state_t state;
  seg_t   tbl [MaxSegments];
  logic [CntBits-1:0] count;
  logic [CntBits-1:0] idx;
  logic [CntBits-1:0] wr;
  logic [IdxBits-1:0] sel;
  logic               sel_ok;
  logic               found;
  logic [AddrBits-1:0] addr;
  logic [AddrBits-1:0] freesum;
  logic [7:0]         owner;
  logic [AddrBits-1:0] req;
  strat_t             strat;
  logic [47:0]        odata;
  logic               olast;
  logic               ovalid;

  seg_t               cur;
  seg_t               nxt;
  seg_t               selseg;
  logic [AddrBits-1:0] sum;
  logic               fits;
  logic               better;

  assign cfg_ready     = (state == S_IDLE) && !ovalid;
  assign s_axis_tready = (state == S_IDLE) && !ovalid && !cfg_valid;
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = odata;
  assign m_axis_tlast  = olast;

  always_comb begin
    cur    = tbl[idx[IdxBits-1:0]];
    nxt    = tbl[idx[IdxBits-1:0] + 1'b1];
    selseg = tbl[sel];
    sum    = '0;
    case (state)
      S_MERGE:   sum = cur.size + nxt.size;
      S_COMPACT: sum = cur.free ? freesum + cur.size : addr + cur.size;
      default:   sum = selseg.start + req;
    endcase
    fits   = cur.free && (cur.size >= req);
    better = (strat == STRAT_BEST)  ? (cur.size < selseg.size) :
             (strat == STRAT_WORST) ? (cur.size > selseg.size) : 1'b0;
  end

  function automatic logic [47:0] pack(status_t st, seg_t s);
    pack = {4'd0, s.owner, s.free, s.size, s.start, st};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      count  <= CntBits'(1);
      for (int i = 0; i < MaxSegments; i++) begin
        if (i == 0) tbl[i] <= '{start: '0, size: AddrBits'(1024), free: 1'b1, owner: 8'd0};
        else tbl[i] <= '0;
      end
    end else begin
      // The dump state drives its own result handshake.
      if (ovalid && m_axis_tready && state != S_DUMP) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            for (int i = 0; i < MaxSegments; i++) begin
              if (i == 0) tbl[i] <= '{start: '0, size: AddrBits'(cfg_data), free: 1'b1,
                                      owner: 8'd0};
              else tbl[i] <= '0;
            end
            count <= CntBits'(1);
          end else if (s_axis_tvalid && s_axis_tready) begin
            owner  <= s_axis_tdata[9:2];
            req    <= s_axis_tdata[25:10];
            strat  <= strat_t'(s_axis_tuser);
            idx    <= '0;
            wr     <= '0;
            sel    <= '0;
            sel_ok <= 1'b0;
            found  <= 1'b0;
            addr   <= '0;
            freesum <= '0;
            case (cmd_t'(s_axis_tdata[1:0]))
              CMD_REQUEST: begin
                if (strat_t'(s_axis_tuser) == STRAT_BAD) begin
                  odata <= pack(ST_BAD_STRATEGY, '0);
                  olast <= 1'b1;
                  state <= S_OUT;
                end else state <= S_SCAN;
              end
              CMD_RELEASE: state <= S_RELEASE;
              CMD_COMPACT: state <= S_COMPACT;
              default: state <= S_DUMP;
            endcase
          end
        end
        S_SCAN: begin
          if (idx < count) begin
            if (fits && (!sel_ok || better)) begin
              sel    <= idx[IdxBits-1:0];
              sel_ok <= 1'b1;
            end
            if (fits && !sel_ok && strat == STRAT_FIRST) idx <= count;
            else idx <= idx + 1'b1;
          end else if (!sel_ok) begin
            odata <= pack(ST_NO_FIT, '0); olast <= 1'b1; state <= S_OUT;
          end else if (selseg.size > req) begin
            if (count >= CntBits'(MaxSegments)) begin
              odata <= pack(ST_TABLE_FULL, '0); olast <= 1'b1; state <= S_OUT;
            end else begin
              idx   <= count;
              state <= S_SHIFT;
            end
          end else begin
            tbl[sel].free  <= 1'b0;
            tbl[sel].owner <= owner;
            odata <= pack(ST_OK, '{start: selseg.start, size: selseg.size,
                                   free: 1'b0, owner: owner});
            olast <= 1'b1;
            state <= S_OUT;
          end
        end
        S_SHIFT: begin
          // Move entries up one slot, from the top down, then split.
          if (idx > CntBits'(sel) + 1'b1) begin
            tbl[idx[IdxBits-1:0]] <= tbl[idx[IdxBits-1:0] - 1'b1];
            idx <= idx - 1'b1;
          end else begin
            tbl[sel + 1'b1] <= '{start: sum, size: selseg.size - req,
                                 free: 1'b1, owner: 8'd0};
            tbl[sel] <= '{start: selseg.start, size: req, free: 1'b0, owner: owner};
            count <= count + 1'b1;
            odata <= pack(ST_OK, '{start: selseg.start, size: req,
                                   free: 1'b0, owner: owner});
            olast <= 1'b1;
            state <= S_OUT;
          end
        end
        S_RELEASE: begin
          if (idx < count) begin
            if (!cur.free && cur.owner == owner) begin
              tbl[idx[IdxBits-1:0]].free  <= 1'b1;
              tbl[idx[IdxBits-1:0]].owner <= 8'd0;
              found <= 1'b1;
            end
            idx <= idx + 1'b1;
          end else if (!found) begin
            odata <= pack(ST_NOT_FOUND, '0); olast <= 1'b1; state <= S_OUT;
          end else begin
            idx   <= '0;
            wr    <= '0;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          // idx is the merge point; wr walks the shift after a merge.
          if (wr != '0) begin
            if (wr + 1'b1 < count) begin
              tbl[wr[IdxBits-1:0]] <= tbl[wr[IdxBits-1:0] + 1'b1];
              wr <= wr + 1'b1;
            end else begin
              tbl[wr[IdxBits-1:0]] <= '0;
              count <= count - 1'b1;
              wr <= '0;
            end
          end else if (idx + 1'b1 < count) begin
            if (cur.free && nxt.free) begin
              tbl[idx[IdxBits-1:0]].size <= sum;
              wr <= idx + 1'b1;
            end else idx <= idx + 1'b1;
          end else begin
            odata <= pack(ST_OK, '0); olast <= 1'b1; state <= S_OUT;
          end
        end
        S_COMPACT: begin
          if (idx < count) begin
            if (cur.free) freesum <= sum;
            else begin
              tbl[wr[IdxBits-1:0]] <= '{start: addr, size: cur.size,
                                         free: 1'b0, owner: cur.owner};
              addr <= sum;
              wr   <= wr + 1'b1;
            end
            idx <= idx + 1'b1;
          end else begin
            // The slot right after the packed entries takes all free space.
            for (int i = 0; i < MaxSegments; i++) begin
              if (CntBits'(i) == wr && freesum != '0)
                tbl[i] <= '{start: addr, size: freesum, free: 1'b1, owner: 8'd0};
              else if (CntBits'(i) >= wr)
                tbl[i] <= '0;
            end
            if (freesum != '0 && wr < CntBits'(MaxSegments)) count <= wr + 1'b1;
            else count <= wr;
            odata <= pack(ST_OK, '0); olast <= 1'b1; state <= S_OUT;
          end
        end
        S_DUMP: begin
          if (!ovalid || m_axis_tready) begin
            if (count == '0) begin
              odata <= pack(ST_OK, '0); olast <= 1'b1; ovalid <= 1'b1;
              state <= S_IDLE;
            end else begin
              odata <= pack(ST_OK, '{start: cur.start, size: cur.size,
                                     free: cur.free,
                                     owner: cur.free ? 8'd0 : cur.owner});
              olast  <= (idx + 1'b1 == count);
              ovalid <= 1'b1;
              idx    <= idx + 1'b1;
              if (idx + 1'b1 == count) state <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          ovalid <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CFA_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CntBits'(MaxSegments))
  `CFA_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, !s_axis_tready)
  `CFA_ASSERT_IMP(a_hold_out, clk, rst, ovalid && !m_axis_tready && state == S_IDLE,
                  !s_axis_tready)
  `CFA_ASSERT_NEXT(a_out_done, clk, rst, state == S_OUT, ovalid)

endmodule
